### rtl/xesp_pkg.sv
// Package for the XMI event stream parser: parse phases, queue command
// format, status codes and the saturating add. No dependencies.
`timescale 1ns / 1ps

package xesp_pkg;

  localparam int unsigned PENDING_DEPTH_DEF = 32;
  localparam int unsigned EVENT_LIMIT_DEF   = 16384;
  localparam int unsigned CMD_FIFO_DEPTH    = 2;
  localparam int unsigned TOTAL_W           = 15;

  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] DELAY_CHAIN  = 8'h7F;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  localparam logic ITEM_MSG = 1'b0;
  localparam logic ITEM_END = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_STATUS,
    PH_META_TYPE,
    PH_META_LEN,
    PH_SYSEX_LEN,
    PH_SKIP,
    PH_NOTE_KEY,
    PH_NOTE_VEL,
    PH_NOTE_DUR,
    PH_DATA1,
    PH_DATA2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_MSG,
    CMD_NOTE,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        final_word;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [31:0] off_tick;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_OFF_OUT,
    B_FETCH,
    B_MOVE,
    B_MSG_OUT,
    B_STORE,
    B_END_OUT
  } back_state_e;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### rtl/xesp_if.sv
// Valid/ready channel interfaces for the byte input and the message output.
// Depends on nothing.
`timescale 1ns / 1ps

interface xesp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface xesp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] event_tick;
  logic [7:0]  status_byte;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [14:0] event_total;
  logic        pending_overflow;
  logic        last_of_run;
  modport source (output valid, item_kind, event_tick, status_byte, first_data, second_data,
                  event_total, pending_overflow, last_of_run, input ready);
  modport sink   (input valid, item_kind, event_tick, status_byte, first_data, second_data,
                  event_total, pending_overflow, last_of_run, output ready);
endinterface

### rtl/xesp_front.sv
// Byte parser: walks delays, meta/sysex skips and channel messages and pushes
// commands into the queue. Depends on xesp_pkg and xesp_if.
`timescale 1ns / 1ps

module xesp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  xesp_in_if.sink         in_i,
  output logic            push_o,
  output xesp_pkg::cmd_t  cmd_o,
  input  logic            space_i
);

  xesp_pkg::phase_e phase_q, phase_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  meta_q, meta_d;
  logic [7:0]  note_q, note_d;
  logic [7:0]  vel_q, vel_d;
  logic        stopped_q, stopped_d;
  logic        end_q, end_d;

  logic        prim_v;
  xesp_pkg::cmd_t prim, end_cmd;
  logic        stop;
  logic [7:0]  b;
  logic [31:0] len_shift;

  assign b         = in_i.data_byte;
  assign len_shift = {len_q[24:0], b[6:0]};
  assign in_i.ready = !end_q && space_i;

  always_comb begin
    end_cmd = '0;
    end_cmd.kind = xesp_pkg::CMD_END;
    end_cmd.final_word = 1'b1;
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    len_d     = len_q;
    status_d  = status_q;
    meta_d    = meta_q;
    note_d    = note_q;
    vel_d     = vel_q;
    stopped_d = stopped_q;
    end_d     = end_q;
    push_o    = 1'b0;
    cmd_o     = end_cmd;
    prim_v    = 1'b0;
    prim      = '0;
    stop      = 1'b0;

    if (end_q) begin
      if (space_i) begin
        push_o = 1'b1;
        end_d  = 1'b0;
      end
    end else if (in_i.valid && in_i.ready) begin
      if (stopped_q) begin
        if (in_i.last_byte) begin
          stopped_d = 1'b0;
          phase_d   = xesp_pkg::PH_IDLE;
          tick_d    = '0;
          len_d     = '0;
          status_d  = '0;
          meta_d    = '0;
          note_d    = '0;
          vel_d     = '0;
        end
      end else begin
        case (phase_q)
          xesp_pkg::PH_IDLE, xesp_pkg::PH_STATUS: begin
            if (!b[7]) begin
              if (phase_q == xesp_pkg::PH_STATUS) begin
                stop = 1'b1;
              end else begin
                tick_d  = xesp_pkg::sat_add(tick_q, {24'd0, b});
                phase_d = (b == xesp_pkg::DELAY_CHAIN) ? xesp_pkg::PH_IDLE
                                                      : xesp_pkg::PH_STATUS;
              end
            end else begin
              status_d = b;
              len_d    = '0;
              if (b == xesp_pkg::ST_META) phase_d = xesp_pkg::PH_META_TYPE;
              else if (b == xesp_pkg::ST_SYSEX || b == xesp_pkg::ST_SYSEX_ESC)
                phase_d = xesp_pkg::PH_SYSEX_LEN;
              else if (b[7:4] == xesp_pkg::HI_NOTE_ON) phase_d = xesp_pkg::PH_NOTE_KEY;
              else phase_d = xesp_pkg::PH_DATA1;
            end
          end
          xesp_pkg::PH_META_TYPE: begin
            meta_d  = b;
            len_d   = '0;
            phase_d = xesp_pkg::PH_META_LEN;
          end
          xesp_pkg::PH_META_LEN, xesp_pkg::PH_SYSEX_LEN: begin
            len_d = len_shift;
            if (!b[7]) begin
              if (phase_q == xesp_pkg::PH_META_LEN && meta_q == xesp_pkg::META_EOT)
                stop = 1'b1;
              else
                phase_d = (len_shift == '0) ? xesp_pkg::PH_IDLE : xesp_pkg::PH_SKIP;
            end
          end
          xesp_pkg::PH_SKIP: begin
            len_d = len_q - 32'd1;
            if (len_q == 32'd1) phase_d = xesp_pkg::PH_IDLE;
          end
          xesp_pkg::PH_NOTE_KEY: begin
            note_d  = b;
            phase_d = xesp_pkg::PH_NOTE_VEL;
          end
          xesp_pkg::PH_NOTE_VEL: begin
            vel_d   = b;
            len_d   = '0;
            phase_d = xesp_pkg::PH_NOTE_DUR;
            if (in_i.last_byte) begin
              prim_v = 1'b1;
              prim.kind = xesp_pkg::CMD_NOTE;
              prim.tick = tick_q;
              prim.status = status_q;
              prim.d1 = note_q;
              prim.d2 = b;
              prim.off_tick = tick_q;
            end
          end
          xesp_pkg::PH_NOTE_DUR: begin
            len_d = len_shift;
            if (!b[7] || in_i.last_byte) begin
              prim_v = 1'b1;
              prim.kind = xesp_pkg::CMD_NOTE;
              prim.tick = tick_q;
              prim.status = status_q;
              prim.d1 = note_q;
              prim.d2 = vel_q;
              prim.off_tick = xesp_pkg::sat_add(tick_q, len_shift);
              phase_d = xesp_pkg::PH_IDLE;
            end
          end
          xesp_pkg::PH_DATA1: begin
            if (status_q[7:4] == xesp_pkg::HI_PROGRAM || status_q[7:4] == xesp_pkg::HI_PRESSURE)
            begin
              prim_v = 1'b1;
              prim.kind = xesp_pkg::CMD_MSG;
              prim.tick = tick_q;
              prim.status = status_q;
              prim.d1 = b;
              phase_d = xesp_pkg::PH_IDLE;
            end else begin
              note_d  = b;
              phase_d = xesp_pkg::PH_DATA2;
            end
          end
          xesp_pkg::PH_DATA2: begin
            prim_v = 1'b1;
            prim.kind = xesp_pkg::CMD_MSG;
            prim.tick = tick_q;
            prim.status = status_q;
            prim.d1 = note_q;
            prim.d2 = b;
            phase_d = xesp_pkg::PH_IDLE;
          end
          default: phase_d = xesp_pkg::PH_IDLE;
        endcase

        if (stop || in_i.last_byte) begin
          push_o = 1'b1;
          if (prim_v) begin
            cmd_o = prim;
            end_d = 1'b1;
          end
          if (in_i.last_byte) begin
            phase_d  = xesp_pkg::PH_IDLE;
            tick_d   = '0;
            len_d    = '0;
            status_d = '0;
            meta_d   = '0;
            note_d   = '0;
            vel_d    = '0;
          end else begin
            stopped_d = 1'b1;
          end
        end else if (prim_v) begin
          push_o = 1'b1;
          cmd_o  = prim;
          cmd_o.final_word = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= xesp_pkg::PH_IDLE;
      tick_q    <= '0;
      len_q     <= '0;
      status_q  <= '0;
      meta_q    <= '0;
      note_q    <= '0;
      vel_q     <= '0;
      stopped_q <= 1'b0;
      end_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      len_q     <= len_d;
      status_q  <= status_d;
      meta_q    <= meta_d;
      note_q    <= note_d;
      vel_q     <= vel_d;
      stopped_q <= stopped_d;
      end_q     <= end_d;
    end
  end

endmodule

### rtl/xesp_cmd_fifo.sv
// Short command queue between parser and executor.
// Depends on xesp_pkg.
`timescale 1ns / 1ps

module xesp_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  xesp_pkg::cmd_t data_i,
  output logic           space_o,
  output logic           valid_o,
  output xesp_pkg::cmd_t data_o,
  input  logic           pop_i
);

  localparam int unsigned D  = xesp_pkg::CMD_FIFO_DEPTH;
  localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW = $clog2(D + 1);

  xesp_pkg::cmd_t mem_q [D];
  logic [PW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;

  assign space_o = cnt_q != CW'(D);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

endmodule

### rtl/xesp_back.sv
// Executor: releases due note-offs from the pending table in tick/generation
// order, emits messages, stores note-offs, flushes. Depends on xesp_pkg, xesp_if.
`timescale 1ns / 1ps

module xesp_back #(
  parameter int unsigned PENDING_DEPTH = xesp_pkg::PENDING_DEPTH_DEF,
  parameter int unsigned EVENT_LIMIT   = xesp_pkg::EVENT_LIMIT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  xesp_pkg::cmd_t cmd_i,
  output logic           pop_o,
  xesp_out_if.source     out_o
);

  localparam int unsigned IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned GW = (EVENT_LIMIT > 1) ? $clog2(EVENT_LIMIT) : 1;
  localparam int unsigned TW = xesp_pkg::TOTAL_W;

  typedef struct packed {
    logic [31:0]   tick;
    logic [GW-1:0] gen;
    logic [3:0]    chan;
    logic [7:0]    note;
  } pend_t;

  pend_t mem [PENDING_DEPTH];
  pend_t rdata_q, best_q, best_d, wdata;
  logic [IW-1:0] raddr, waddr, rslot_q, rslot_d, bslot_q, bslot_d;
  logic          we;

  xesp_pkg::back_state_e st_q, st_d;
  xesp_pkg::cmd_t cmd_q, cmd_d;
  logic [CW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic          rv_q, rv_d, found_q, found_d;
  logic [TW-1:0] gc_q, gc_d;
  logic          ov_q, ov_d;
  logic [31:0]   limit_q, limit_d;
  logic          at_limit, better;

  assign at_limit = gc_q >= TW'(EVENT_LIMIT);
  assign better = (rdata_q.tick <= limit_q) &&
                  (!found_q || rdata_q.tick < best_q.tick ||
                   (rdata_q.tick == best_q.tick && rdata_q.gen < best_q.gen));

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_comb begin
    st_d    = st_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    rv_d    = 1'b0;
    rslot_d = rslot_q;
    found_d = found_q;
    best_d  = best_q;
    bslot_d = bslot_q;
    gc_d    = gc_q;
    ov_d    = ov_q;
    limit_d = limit_q;
    pop_o   = 1'b0;
    raddr   = idx_q[IW-1:0];
    we      = 1'b0;
    waddr   = bslot_q;
    wdata   = rdata_q;

    case (st_q)
      xesp_pkg::B_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          idx_d   = '0;
          found_d = 1'b0;
          if (cmd_i.kind == xesp_pkg::CMD_END) begin
            limit_d = 32'hFFFF_FFFF;
            st_d    = xesp_pkg::B_SCAN;
          end else if (!at_limit) begin
            limit_d = cmd_i.tick;
            st_d    = xesp_pkg::B_SCAN;
          end
        end
      end
      xesp_pkg::B_SCAN: begin
        if (idx_q < cnt_q) begin
          idx_d   = idx_q + 1'b1;
          rv_d    = 1'b1;
          rslot_d = idx_q[IW-1:0];
        end
        if (rv_q && better) begin
          found_d = 1'b1;
          best_d  = rdata_q;
          bslot_d = rslot_q;
        end
        if (idx_q == cnt_q && !rv_q) begin
          if (found_q) st_d = xesp_pkg::B_OFF_OUT;
          else if (cmd_q.kind == xesp_pkg::CMD_END) st_d = xesp_pkg::B_END_OUT;
          else st_d = xesp_pkg::B_MSG_OUT;
        end
      end
      xesp_pkg::B_OFF_OUT: begin
        if (out_o.ready) st_d = xesp_pkg::B_FETCH;
      end
      xesp_pkg::B_FETCH: begin
        raddr = IW'(cnt_q - 1'b1);
        st_d  = xesp_pkg::B_MOVE;
      end
      xesp_pkg::B_MOVE: begin
        we      = 1'b1;
        cnt_d   = cnt_q - 1'b1;
        idx_d   = '0;
        found_d = 1'b0;
        st_d    = xesp_pkg::B_SCAN;
      end
      xesp_pkg::B_MSG_OUT: begin
        if (out_o.ready) begin
          gc_d = gc_q + 1'b1;
          st_d = (cmd_q.kind == xesp_pkg::CMD_NOTE) ? xesp_pkg::B_STORE : xesp_pkg::B_IDLE;
        end
      end
      xesp_pkg::B_STORE: begin
        st_d = xesp_pkg::B_IDLE;
        if (!at_limit) begin
          if (cnt_q >= CW'(PENDING_DEPTH)) begin
            ov_d = 1'b1;
          end else begin
            we         = 1'b1;
            waddr      = cnt_q[IW-1:0];
            wdata.tick = cmd_q.off_tick;
            wdata.gen  = gc_q[GW-1:0];
            wdata.chan = cmd_q.status[3:0];
            wdata.note = cmd_q.d1;
            cnt_d      = cnt_q + 1'b1;
            gc_d       = gc_q + 1'b1;
          end
        end
      end
      xesp_pkg::B_END_OUT: begin
        if (out_o.ready) begin
          cnt_d = '0;
          gc_d  = '0;
          ov_d  = 1'b0;
          st_d  = xesp_pkg::B_IDLE;
        end
      end
      default: st_d = xesp_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    out_o.valid            = 1'b0;
    out_o.item_kind        = xesp_pkg::ITEM_MSG;
    out_o.event_tick       = '0;
    out_o.status_byte      = '0;
    out_o.first_data       = '0;
    out_o.second_data      = '0;
    out_o.event_total      = '0;
    out_o.pending_overflow = ov_q;
    out_o.last_of_run      = 1'b0;
    case (st_q)
      xesp_pkg::B_OFF_OUT: begin
        out_o.valid       = 1'b1;
        out_o.event_tick  = best_q.tick;
        out_o.status_byte = {xesp_pkg::HI_NOTE_OFF, best_q.chan};
        out_o.first_data  = best_q.note;
      end
      xesp_pkg::B_MSG_OUT: begin
        out_o.valid       = 1'b1;
        out_o.event_tick  = cmd_q.tick;
        out_o.status_byte = cmd_q.status;
        out_o.first_data  = cmd_q.d1;
        out_o.second_data = cmd_q.d2;
        out_o.last_of_run = cmd_q.final_word;
      end
      xesp_pkg::B_END_OUT: begin
        out_o.valid       = 1'b1;
        out_o.item_kind   = xesp_pkg::ITEM_END;
        out_o.event_total = gc_q;
        out_o.last_of_run = 1'b1;
      end
      default: out_o.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= xesp_pkg::B_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
      gc_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      found_q <= found_d;
      gc_q    <= gc_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    rslot_q <= rslot_d;
    best_q  <= best_d;
    bslot_q <= bslot_d;
    limit_q <= limit_d;
  end

endmodule

### rtl/xmi_event_stream_parser_core.sv
// XMI event stream parser top level: parser front end, command queue, executor.
// Depends on xesp_pkg, xesp_if, xesp_front, xesp_cmd_fifo, xesp_back.
//
// Takes one chunk byte per word and gives MIDI messages in tick order, then an
// end marker. A byte is taken in one cycle unless the two-entry command queue
// is full; a final byte that also completes a message holds off the next byte
// until its end marker is pushed. Each message or end marker leaves the queue,
// then the pending table is scanned through the registered read port of the
// pending memory and the output word is sent; a note-on stores its note-off;
// a released note-off's slot takes the last entry and the table is rescanned.
// No new command is taken before the last is done. No reset sweep is needed.
`timescale 1ns / 1ps

module xmi_event_stream_parser_core #(
  parameter int unsigned PENDING_DEPTH = xesp_pkg::PENDING_DEPTH_DEF,
  parameter int unsigned EVENT_LIMIT   = xesp_pkg::EVENT_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  xesp_in_if.sink     in_ch_i,
  xesp_out_if.source  out_ch_o
);

  logic           push, space, qvalid, pop;
  xesp_pkg::cmd_t push_cmd, q_cmd;

  xesp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch_i),
    .push_o  (push),
    .cmd_o   (push_cmd),
    .space_i (space)
  );

  xesp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .space_o (space),
    .valid_o (qvalid),
    .data_o  (q_cmd),
    .pop_i   (pop)
  );

  xesp_back #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .EVENT_LIMIT   (EVENT_LIMIT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qvalid),
    .cmd_i   (q_cmd),
    .pop_o   (pop),
    .out_o   (out_ch_o)
  );

endmodule

### sim/tb_xmi_event_stream_parser_core.sv
// Testbench for the XMI event stream parser: drives chunk bytes with random
// gaps, predicts messages and end markers, checks each output word.
// Depends on xesp_pkg, xesp_if and the parser core.
`timescale 1ns / 1ps

module tb_xmi_event_stream_parser_core;

  typedef struct {
    logic        kind;
    logic [31:0] tick;
    logic [7:0]  st;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [14:0] total;
    logic        ovf;
    logic        lst;
  } word_t;

  typedef struct {
    logic [31:0] tick;
    int unsigned gen;
    logic [7:0]  st;
    logic [7:0]  note;
  } off_t;

  localparam int unsigned DEPTH = xesp_pkg::PENDING_DEPTH_DEF;
  localparam int unsigned LIMIT = xesp_pkg::EVENT_LIMIT_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  xesp_in_if  in_ch ();
  xesp_out_if out_ch ();

  xmi_event_stream_parser_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  // parser shadow state
  xesp_pkg::phase_e m_phase;
  logic [31:0] m_tick, m_len;
  logic [7:0]  m_status, m_meta, m_note, m_vel;
  off_t        m_offs[DEPTH];
  int unsigned m_count, m_gen;
  logic        m_ovf, m_stopped;

  word_t expected_words[$];
  word_t step_words[$];
  int    mismatches = 0;
  int    rx_stall_mode = 0;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_parser();
    m_phase = xesp_pkg::PH_IDLE; m_tick = '0; m_len = '0; m_status = '0; m_meta = '0;
    m_note = '0; m_vel = '0; m_count = 0; m_gen = 0; m_ovf = 1'b0;
    m_stopped = 1'b0;
  endfunction

  function automatic void push_word(logic k, logic [31:0] t, logic [7:0] s, logic [7:0] a,
                                    logic [7:0] b, logic [14:0] tot);
    word_t w;
    w.kind = k; w.tick = t; w.st = s; w.d1 = a; w.d2 = b; w.total = tot;
    w.ovf = m_ovf; w.lst = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void release_offs(logic [31:0] lim);
    int best;
    forever begin
      best = -1;
      for (int i = 0; i < m_count; i++) begin
        if (m_offs[i].tick > lim) continue;
        if (best < 0 || m_offs[i].tick < m_offs[best].tick ||
            (m_offs[i].tick == m_offs[best].tick && m_offs[i].gen < m_offs[best].gen))
          best = i;
      end
      if (best < 0) break;
      push_word(xesp_pkg::ITEM_MSG, m_offs[best].tick, m_offs[best].st, m_offs[best].note,
                8'h00, '0);
      m_offs[best] = m_offs[m_count - 1];
      m_count--;
    end
  endfunction

  function automatic void emit_msg(logic [31:0] t, logic [7:0] s, logic [7:0] a,
                                   logic [7:0] b);
    if (m_gen >= LIMIT) return;
    release_offs(t);
    push_word(xesp_pkg::ITEM_MSG, t, s, a, b, '0);
    m_gen++;
  endfunction

  function automatic void note_on(logic [31:0] dur);
    logic [31:0] off;
    off = add_sat(m_tick, dur);
    emit_msg(m_tick, m_status, m_note, m_vel);
    if (m_gen >= LIMIT) return;
    if (m_count >= DEPTH) begin
      m_ovf = 1'b1;
      return;
    end
    m_offs[m_count].tick = off;
    m_offs[m_count].gen  = m_gen;
    m_offs[m_count].st   = {xesp_pkg::HI_NOTE_OFF, m_status[3:0]};
    m_offs[m_count].note = m_note;
    m_count++;
    m_gen++;
  endfunction

  function automatic void open_status(logic [7:0] s);
    m_status = s;
    m_len = '0;
    if (s == xesp_pkg::ST_META) m_phase = xesp_pkg::PH_META_TYPE;
    else if (s == xesp_pkg::ST_SYSEX || s == xesp_pkg::ST_SYSEX_ESC)
      m_phase = xesp_pkg::PH_SYSEX_LEN;
    else if (s[7:4] == xesp_pkg::HI_NOTE_ON) m_phase = xesp_pkg::PH_NOTE_KEY;
    else m_phase = xesp_pkg::PH_DATA1;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic lst);
    logic stop;
    stop = 1'b0;
    step_words.delete();
    if (m_stopped) begin
      if (lst) clear_parser();
      return;
    end
    case (m_phase)
      xesp_pkg::PH_IDLE: begin
        if (!b[7]) begin
          m_tick = add_sat(m_tick, {24'd0, b});
          m_phase = (b == xesp_pkg::DELAY_CHAIN) ? xesp_pkg::PH_IDLE : xesp_pkg::PH_STATUS;
        end else open_status(b);
      end
      xesp_pkg::PH_STATUS: begin
        if (!b[7]) stop = 1'b1;
        else open_status(b);
      end
      xesp_pkg::PH_META_TYPE: begin
        m_meta = b; m_len = '0; m_phase = xesp_pkg::PH_META_LEN;
      end
      xesp_pkg::PH_META_LEN, xesp_pkg::PH_SYSEX_LEN: begin
        m_len = {m_len[24:0], b[6:0]};
        if (!b[7]) begin
          if (m_phase == xesp_pkg::PH_META_LEN && m_meta == xesp_pkg::META_EOT) stop = 1'b1;
          else m_phase = (m_len == 0) ? xesp_pkg::PH_IDLE : xesp_pkg::PH_SKIP;
        end
      end
      xesp_pkg::PH_SKIP: begin
        m_len--;
        if (m_len == 0) m_phase = xesp_pkg::PH_IDLE;
      end
      xesp_pkg::PH_NOTE_KEY: begin
        m_note = b; m_phase = xesp_pkg::PH_NOTE_VEL;
      end
      xesp_pkg::PH_NOTE_VEL: begin
        m_vel = b; m_len = '0; m_phase = xesp_pkg::PH_NOTE_DUR;
        if (lst) note_on('0);
      end
      xesp_pkg::PH_NOTE_DUR: begin
        m_len = {m_len[24:0], b[6:0]};
        if (!b[7] || lst) begin
          note_on(m_len);
          m_phase = xesp_pkg::PH_IDLE;
        end
      end
      xesp_pkg::PH_DATA1: begin
        if (m_status[7:4] == xesp_pkg::HI_PROGRAM || m_status[7:4] == xesp_pkg::HI_PRESSURE)
        begin
          emit_msg(m_tick, m_status, b, 8'h00);
          m_phase = xesp_pkg::PH_IDLE;
        end else begin
          m_note = b; m_phase = xesp_pkg::PH_DATA2;
        end
      end
      xesp_pkg::PH_DATA2: begin
        emit_msg(m_tick, m_status, m_note, b);
        m_phase = xesp_pkg::PH_IDLE;
      end
      default: m_phase = xesp_pkg::PH_IDLE;
    endcase
    if (stop || lst) begin
      release_offs(32'hFFFF_FFFF);
      push_word(xesp_pkg::ITEM_END, '0, '0, '0, '0, m_gen[14:0]);
      if (lst) clear_parser();
      else m_stopped = 1'b1;
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].lst = 1'b1;
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    clear_parser();
  end

  // sender: bursts of random length with random gaps
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_byte(b, lst);
    burst_left--;
  endtask

  task automatic finish_sending();
    in_ch.valid <= 1'b0;
    in_ch.last_byte <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_varlen(input logic [31:0] v);
    logic [7:0] g[$];
    g.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      g.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (g[i]) send_byte(g[i], 1'b0);
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else case (rx_stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    word_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word kind=%0d tick=%0h st=%0h",
                                       out_ch.item_kind, out_ch.event_tick,
                                       out_ch.status_byte);
      end else begin
        e = expected_words.pop_front();
        if (out_ch.item_kind !== e.kind || out_ch.event_tick !== e.tick ||
            out_ch.status_byte !== e.st || out_ch.first_data !== e.d1 ||
            out_ch.second_data !== e.d2 || out_ch.event_total !== e.total ||
            out_ch.pending_overflow !== e.ovf || out_ch.last_of_run !== e.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d t%0h s%0h %0h %0h n%0d o%0d l%0d got k%0d t%0h s%0h %0h %0h n%0d o%0d l%0d",
                     e.kind, e.tick, e.st, e.d1, e.d2, e.total, e.ovf, e.lst,
                     out_ch.item_kind, out_ch.event_tick, out_ch.status_byte,
                     out_ch.first_data, out_ch.second_data, out_ch.event_total,
                     out_ch.pending_overflow, out_ch.last_of_run);
        end
      end
    end
  end

  task automatic test_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h90, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h85, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'h10, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'hDF, 1'b0); send_byte(8'h55, 1'b0);
    send_byte(8'hB0, 1'b0); send_byte(8'h07, 1'b0); send_byte(8'h64, 1'b0);
    send_byte(8'hE1, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h40, 1'b1);
  endtask

  task automatic test_meta_sysex_stop();
    send_byte(8'hFF, 1'b0); send_byte(8'h51, 1'b0); send_byte(8'h02, 1'b0);
    send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h05, 1'b0);
    repeat (5) send_byte(8'($urandom), 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h90, 1'b0); send_byte(8'h3C, 1'b0); send_byte(8'h40, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h2F, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h90, 1'b0); send_byte(8'h05, 1'b1);
    // non-status byte right after a delay
    send_byte(8'h90, 1'b0); send_byte(8'h30, 1'b0); send_byte(8'h30, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h05, 1'b0); send_byte(8'h22, 1'b0); send_byte(8'h01, 1'b1);
  endtask

  task automatic test_truncation();
    send_byte(8'h91, 1'b0); send_byte(8'h40, 1'b0); send_byte(8'h70, 1'b1);
    send_byte(8'h92, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'h71, 1'b0);
    send_byte(8'h83, 1'b1);
    send_byte(8'hB2, 1'b0); send_byte(8'h41, 1'b1);
  endtask

  task automatic test_saturation_overflow();
    for (int i = 0; i < 5; i++) send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h9F, 1'b0); send_byte(8'h10, 1'b0); send_byte(8'h20, 1'b0);
    send_varlen(32'hFFFF_FFF0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b1);
    for (int i = 0; i < 34; i++) begin
      send_byte({4'h9, 4'(i)}, 1'b0); send_byte(8'(i), 1'b0);
      send_byte(8'h7F, 1'b0); send_byte(8'(100 - i), 1'b0);
    end
    send_byte(8'hC0, 1'b0); send_byte(8'h01, 1'b1);
  endtask

  task automatic test_random_chunks();
    int sent;
    int sel;
    sent = 0;
    while (sent < 140) begin
      rx_stall_mode = $urandom_range(0, 2);
      for (int e = $urandom_range(2, 12); e > 0; e--) begin
        if ($urandom_range(0, 2) != 0) begin
          send_byte(8'($urandom_range(0, 127)), 1'b0); sent++;
        end
        sel = $urandom_range(0, 19);
        if (sel < 8) begin
          send_byte({4'h9, 4'($urandom)}, 1'b0);
          send_byte(8'($urandom), 1'b0); send_byte(8'($urandom), 1'b0);
          send_varlen($urandom_range(0, 300)); sent += 4;
        end else if (sel < 15) begin
          send_byte({1'b1, 3'($urandom_range(0, 6)), 4'($urandom)}, 1'b0);
          send_byte(8'($urandom), 1'b0); send_byte(8'($urandom), 1'b0); sent += 3;
        end else if (sel < 17) begin
          send_byte($urandom_range(0, 1) ? xesp_pkg::ST_META : xesp_pkg::ST_SYSEX, 1'b0);
          send_byte(8'($urandom), 1'b0);
          send_byte(8'($urandom_range(0, 3)), 1'b0); sent += 3;
        end else begin
          send_byte(8'($urandom), $urandom_range(0, 15) == 0); sent++;
        end
      end
      send_byte(8'($urandom), 1'b1); sent++;
    end
  endtask

  initial begin
    int guard;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rx_stall_mode = 0;
    test_extremes();
    rx_stall_mode = 1;
    test_meta_sysex_stop();
    test_truncation();
    rx_stall_mode = 2;
    test_saturation_overflow();
    test_random_chunks();
    finish_sending();
    guard = 0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
